>>> rtl/hcs_pkg.sv
// Shared types and constants for the hash collision search unit.
`default_nettype none

package hcs_pkg;

    localparam int IMAGE_W    = 64;
    localparam int HALF_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int OUT_DATA_W = 136;
    localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - 2 * IMAGE_W;

    // image = x * LCG_MUL + LCG_ADD (mod 2^64), multiplier split into halves
    localparam logic [HALF_W-1:0]  LCG_MUL_LO = 32'h4C95_7F2D;
    localparam logic [HALF_W-1:0]  LCG_MUL_HI = 32'h5851_F42D;
    localparam logic [IMAGE_W-1:0] LCG_ADD    = 64'h1405_7B7E_F767_814F;

    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_COLLISION = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_REPEAT    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_HALTED    = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SUM,
        S_MUL,
        S_HIGH,
        S_QUOT,
        S_REM,
        S_DECIDE
    } hcs_state_t;

endpackage

`default_nettype wire

>>> rtl/hash_collision_search_unit.sv
// Top level: birthday-style collision search over a bucketed hash table.
//
//   channel  dir  payload (low bit first)                 request accepted when
//   s_*      in   tdata: candidate[63:0]                  s_tvalid && s_tready
//   m_*      out  tdata: status[2:0] image[66:3]          m_tvalid && m_tready
//                        partner[130:67] zero[135:131]
//
// Power-of-two BUCKETS: each request passes accept, multiply-sum with bucket read,
// and compare and write-back. Other BUCKETS put the bucket remainder between the
// multiply-sum and the compare: reciprocal partial products, high word, quotient,
// and remainder with bucket read. A new request is taken only after write-back.
// After reset every address of the valid memory is swept clear; s_tready stays low.
// The write-back cycle waits while the output register holds an untaken result.
`default_nettype none

module hash_collision_search_unit
    import hcs_pkg::*;
#(
    parameter int BUCKETS = 4096,
    parameter int WAYS    = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IMAGE_W-1:0]    s_tdata,   // candidate[63:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata    // status, image, partner, zero pad
);

    localparam int  BW      = $clog2(BUCKETS);
    localparam int  ENTRY_W = 2 * IMAGE_W;
    localparam int  ROW_W   = WAYS * ENTRY_W;
    localparam bit  POW2    = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam logic [BW-1:0] LAST_BKT  = BW'(BUCKETS - 1);
    localparam logic [BW-1:0] BKT_W     = BW'(BUCKETS);

    // quotient by multiply-high with a 64-bit magic number plus a one-bit fixup
    localparam logic [127:0] GM_SPAN = (128'(1) << BW) - 128'(BUCKETS);
    localparam logic [127:0] GM_MULT = ((GM_SPAN << IMAGE_W) / 128'(BUCKETS)) + 128'(1);
    localparam logic [HALF_W-1:0] GM_M_LO = GM_MULT[HALF_W-1:0];
    localparam logic [HALF_W-1:0] GM_M_HI = GM_MULT[IMAGE_W-1:HALF_W];

    hcs_state_t state_reg, state_next;

    logic [IMAGE_W-1:0]    cand_reg;
    logic [IMAGE_W-1:0]    pll_reg;
    logic [HALF_W-1:0]     plh_reg;
    logic [HALF_W-1:0]     phl_reg;
    logic [IMAGE_W-1:0]    image_reg;
    logic [IMAGE_W-1:0]    image_next;
    logic [BW-1:0]         bucket_reg;
    logic [BW-1:0]         rem_next;
    logic [IMAGE_W-1:0]    gm_ll_reg;
    logic [IMAGE_W-1:0]    gm_lh_reg;
    logic [IMAGE_W-1:0]    gm_hl_reg;
    logic [IMAGE_W-1:0]    gm_hh_reg;
    logic [IMAGE_W-1:0]    gm_t_reg;
    logic [IMAGE_W-1:0]    gm_t_next;
    logic [BW-1:0]         quot_reg;
    logic [BW-1:0]         quot_next;
    logic [BW-1:0]         clr_cnt_reg;
    logic                  halted_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic [IMAGE_W-1:0] prod_ll;
    logic [HALF_W-1:0]  prod_lh;
    logic [HALF_W-1:0]  prod_hl;

    logic [IMAGE_W-1:0] gm_ll;
    logic [IMAGE_W-1:0] gm_lh;
    logic [IMAGE_W-1:0] gm_hl;
    logic [IMAGE_W-1:0] gm_hh;

    // memory ports
    logic             rd_en;
    logic [BW-1:0]    rd_addr;
    logic             v_we;
    logic [BW-1:0]    v_waddr;
    logic [WAYS-1:0]  v_wdata;
    logic [WAYS-1:0]  v_rdata;
    logic             e_we;
    logic [ROW_W-1:0] e_wdata;
    logic [ROW_W-1:0] e_rdata;

    // compare results
    logic                matched;
    logic                free_found;
    logic [WAYS-1:0]     free_oh;
    logic [IMAGE_W-1:0]  hit_input;
    logic                out_free;
    logic                do_insert;
    logic                new_halt;
    logic [STATUS_W-1:0] status;
    logic [IMAGE_W-1:0]  partner;

    // ---------------------------------------------------------------- datapath
    assign prod_ll = IMAGE_W'(s_tdata[HALF_W-1:0]) * IMAGE_W'(LCG_MUL_LO);
    assign prod_lh = s_tdata[HALF_W-1:0] * LCG_MUL_HI;
    assign prod_hl = s_tdata[IMAGE_W-1:HALF_W] * LCG_MUL_LO;

    assign image_next = pll_reg + {plh_reg + phl_reg, {HALF_W{1'b0}}} + LCG_ADD;

    // bucket remainder for other bucket counts, one stage per cycle
    assign gm_ll = IMAGE_W'(image_reg[HALF_W-1:0]) * IMAGE_W'(GM_M_LO);
    assign gm_lh = IMAGE_W'(image_reg[IMAGE_W-1:HALF_W]) * IMAGE_W'(GM_M_LO);
    assign gm_hl = IMAGE_W'(image_reg[HALF_W-1:0]) * IMAGE_W'(GM_M_HI);
    assign gm_hh = IMAGE_W'(image_reg[IMAGE_W-1:HALF_W]) * IMAGE_W'(GM_M_HI);

    always_comb begin
        logic [HALF_W+1:0] mid;
        mid = {2'b00, gm_ll_reg[IMAGE_W-1:HALF_W]} + {2'b00, gm_lh_reg[HALF_W-1:0]}
            + {2'b00, gm_hl_reg[HALF_W-1:0]};
        gm_t_next = gm_hh_reg + {{HALF_W{1'b0}}, gm_lh_reg[IMAGE_W-1:HALF_W]}
                  + {{HALF_W{1'b0}}, gm_hl_reg[IMAGE_W-1:HALF_W]}
                  + {{(IMAGE_W-2){1'b0}}, mid[HALF_W+1:HALF_W]};
    end

    always_comb begin
        logic [IMAGE_W-1:0] q_full;
        q_full    = gm_t_reg + ((image_reg - gm_t_reg) >> 1);
        quot_next = BW'(q_full >> (BW - 1));
    end

    // remainder is below BUCKETS, so the low bits of image - q * BUCKETS are exact
    assign rem_next = image_reg[BW-1:0] - quot_reg * BKT_W;

    always_comb begin
        logic [IMAGE_W-1:0] w_img;
        logic [IMAGE_W-1:0] w_inp;
        matched    = 1'b0;
        free_found = 1'b0;
        free_oh    = '0;
        hit_input  = '0;
        e_wdata    = e_rdata;
        for (int w = 0; w < WAYS; w++) begin
            w_img = e_rdata[w*ENTRY_W +: IMAGE_W];
            w_inp = e_rdata[w*ENTRY_W+IMAGE_W +: IMAGE_W];
            if (v_rdata[w]) begin
                if (!matched && w_img == image_reg) begin
                    matched   = 1'b1;
                    hit_input = w_inp;
                end
            end else if (!free_found) begin
                free_found = 1'b1;
                free_oh[w] = 1'b1;
                e_wdata[w*ENTRY_W +: ENTRY_W] = {cand_reg, image_reg};
            end
        end
    end

    always_comb begin
        partner = '0;
        if (halted_reg) begin
            status = STAT_HALTED;
        end else if (matched) begin
            if (hit_input != cand_reg) begin
                status  = STAT_COLLISION;
                partner = hit_input;
            end else begin
                status = STAT_REPEAT;
            end
        end else if (free_found) begin
            status = STAT_INSERTED;
        end else begin
            status = STAT_FULL;
        end
    end

    assign out_free  = !m_tvalid_reg || m_tready;
    assign do_insert = !halted_reg && !matched && free_found;
    assign new_halt  = !halted_reg && matched && (hit_input != cand_reg);

    // ------------------------------------------------------------- state machine
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (clr_cnt_reg == LAST_BKT) state_next = S_IDLE;
            S_IDLE:   if (s_tvalid) state_next = S_SUM;
            S_SUM:    state_next = POW2 ? S_DECIDE : S_MUL;
            S_MUL:    state_next = S_HIGH;
            S_HIGH:   state_next = S_QUOT;
            S_QUOT:   state_next = S_REM;
            S_REM:    state_next = S_DECIDE;
            S_DECIDE: if (out_free) state_next = S_IDLE;
            default:  state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = bucket_reg;
        v_we     = 1'b0;
        v_waddr  = bucket_reg;
        v_wdata  = v_rdata | free_oh;
        e_we     = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                v_we    = 1'b1;
                v_waddr = clr_cnt_reg;
                v_wdata = '0;
            end
            S_IDLE: begin
                s_tready = 1'b1;
            end
            S_SUM: begin
                // power-of-two buckets: bucket is the low image bits
                rd_en   = POW2;
                rd_addr = image_next[BW-1:0];
            end
            S_MUL, S_HIGH, S_QUOT: begin
            end
            S_REM: begin
                rd_en   = 1'b1;
                rd_addr = rem_next;
            end
            S_DECIDE: begin
                v_we = out_free && do_insert;
                e_we = out_free && do_insert;
            end
            default: begin
            end
        endcase
    end

    // ----------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            halted_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + BW'(1);
            end
            if (state_reg == S_DECIDE && out_free) begin
                m_tvalid_reg <= 1'b1;
                if (new_halt) begin
                    halted_reg <= 1'b1;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cand_reg <= s_tdata;
            pll_reg  <= prod_ll;
            plh_reg  <= prod_lh;
            phl_reg  <= prod_hl;
        end
        if (state_reg == S_SUM) begin
            image_reg  <= image_next;
            bucket_reg <= POW2 ? image_next[BW-1:0] : '0;
        end else if (state_reg == S_REM) begin
            bucket_reg <= rem_next;
        end
        if (state_reg == S_MUL) begin
            gm_ll_reg <= gm_ll;
            gm_lh_reg <= gm_lh;
            gm_hl_reg <= gm_hl;
            gm_hh_reg <= gm_hh;
        end
        if (state_reg == S_HIGH) begin
            gm_t_reg <= gm_t_next;
        end
        if (state_reg == S_QUOT) begin
            quot_reg <= quot_next;
        end
        if (state_reg == S_DECIDE && out_free) begin
            m_tdata_reg <= {{OUT_PAD_W{1'b0}}, partner, image_reg, status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------ memories
    hcs_ram #(
        .WIDTH (WAYS),
        .DEPTH (BUCKETS)
    ) u_valid_ram (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (v_rdata)
    );

    hcs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (e_we),
        .waddr (bucket_reg),
        .wdata (e_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (e_rdata)
    );

endmodule

`default_nettype wire

>>> rtl/hcs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module hcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/hcs_checker.sv
// Port-level checker for the hash collision search unit, bound to the top level.
`default_nettype none

module hcs_checker
    import hcs_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] status;
    logic [IMAGE_W-1:0]  partner;

    assign status  = m_tdata[STATUS_W-1:0];
    assign partner = m_tdata[STATUS_W+IMAGE_W +: IMAGE_W];

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> status <= STAT_HALTED)
        else $error("status code out of range");

    a_partner_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status != STAT_COLLISION |-> partner == '0)
        else $error("partner nonzero without collision");

    a_halt_after_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && status == STAT_COLLISION
            |=> !m_tvalid || status == STAT_HALTED)
        else $error("result after collision not halted");

endmodule

bind hash_collision_search_unit hcs_checker u_hcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/tb_hash_collision_search_unit.sv
// Self-checking testbench for the hash collision search unit: bucket-table predictor and stream driver.
`default_nettype none

module tb_hash_collision_search_unit
    import hcs_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUCKET_BITS  = 12;
    localparam int BUCKET_CNT   = 1 << BUCKET_BITS;
    localparam int WAY_CNT      = 4;
    localparam int RANDOM_ITEMS = 345;      // per idling phase
    localparam int HOT_CNT      = 24;
    localparam int STALL_LIMIT  = 20000;    // covers the clear sweep after reset
    localparam int MAX_PRINTS   = 100;

    localparam logic [IMAGE_W-1:0] MIX_MUL = 64'h5851_F42D_4C95_7F2D;
    localparam logic [IMAGE_W-1:0] MIX_INC = 64'h1405_7B7E_F767_814F;

    // bucket extremes, repeats and bucket overflow; low 12 candidate bits pick the bucket
    localparam logic [IMAGE_W-1:0] DIRECTED [20] = '{
        64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
        64'h0000_0000_0000_1000, 64'h0000_0000_0000_2000,
        64'h0000_0000_0000_4000, 64'h0000_0000_0000_8000,
        64'h0000_0000_0000_1000, 64'h0000_0000_0000_4000,
        64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0FFF,
        64'h0000_0000_0000_1FFF, 64'h0000_0000_0000_2FFF,
        64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_F000
    };

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [IMAGE_W-1:0]  image;
        logic [IMAGE_W-1:0]  partner;
    } search_result_t;

    class bucket_table_model;
        bit [WAY_CNT-1:0]   way_valid  [BUCKET_CNT];
        bit [IMAGE_W-1:0]   kept_image [BUCKET_CNT*WAY_CNT];
        bit [IMAGE_W-1:0]   kept_input [BUCKET_CNT*WAY_CNT];
        bit                 halted;
        search_result_t     awaited_results [$];
        int                 errors;

        function logic [IMAGE_W-1:0] one_way(logic [IMAGE_W-1:0] x);
            return x * MIX_MUL + MIX_INC;
        endfunction

        function void note_request(logic [IMAGE_W-1:0] cand);
            search_result_t     res;
            logic [IMAGE_W-1:0] img;
            int                 bucket;
            int                 free_way;
            int                 slot;
            bit                 matched;
            img         = one_way(cand);
            bucket      = int'(img[BUCKET_BITS-1:0]);
            free_way    = -1;
            matched     = 1'b0;
            res.status  = STAT_FULL;
            res.image   = img;
            res.partner = '0;
            if (halted) begin
                res.status = STAT_HALTED;
            end else begin
                for (int w = 0; w < WAY_CNT; w++) begin
                    slot = bucket * WAY_CNT + w;
                    if (way_valid[bucket][w]) begin
                        if (!matched && kept_image[slot] == img) begin
                            matched = 1'b1;
                            if (kept_input[slot] != cand) begin
                                res.status  = STAT_COLLISION;
                                res.partner = kept_input[slot];
                                halted      = 1'b1;
                            end else begin
                                res.status = STAT_REPEAT;
                            end
                        end
                    end else if (free_way < 0) begin
                        free_way = w;
                    end
                end
                if (!matched && free_way >= 0) begin
                    slot                       = bucket * WAY_CNT + free_way;
                    kept_image[slot]           = img;
                    kept_input[slot]           = cand;
                    way_valid[bucket][free_way] = 1'b1;
                    res.status                 = STAT_INSERTED;
                end
            end
            awaited_results.push_back(res);
        endfunction

        task report(string what);
            if (errors < MAX_PRINTS)
                $display("%0t ns: mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [OUT_DATA_W-1:0] data);
            search_result_t      want;
            logic [STATUS_W-1:0] got_status;
            logic [IMAGE_W-1:0]  got_image;
            logic [IMAGE_W-1:0]  got_partner;
            got_status  = data[STATUS_W-1:0];
            got_image   = data[STATUS_W +: IMAGE_W];
            got_partner = data[STATUS_W+IMAGE_W +: IMAGE_W];
            if (awaited_results.size() == 0) begin
                report($sformatf("unexpected result, status %0d image %h",
                                 got_status, got_image));
            end else begin
                want = awaited_results.pop_front();
                if (got_status !== want.status)
                    report($sformatf("status %0d, want %0d (image %h)",
                                     got_status, want.status, want.image));
                if (got_image !== want.image)
                    report($sformatf("image %h, want %h", got_image, want.image));
                if (got_partner !== want.partner)
                    report($sformatf("partner %h, want %h (image %h)",
                                     got_partner, want.partner, want.image));
            end
        endtask
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IMAGE_W-1:0]    s_tdata  = '0;      // candidate[63:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;            // status, image, partner, zero pad

    bucket_table_model     tracker = new();
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    bit                    hold_ready     = 1'b0;
    int                    quiet_cycles   = 0;
    logic [IMAGE_W-1:0]    sent_log [$];
    logic [BUCKET_BITS-1:0] hot_low [HOT_CNT];

    hash_collision_search_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        if (hold_ready)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // results first, then the new request, so the queue order stays fixed
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata);
            if (s_tvalid && s_tready)
                tracker.note_request(s_tdata);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_hash_collision_search_unit failed");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at a falling edge with s_tvalid still high
    task send_candidate(input logic [IMAGE_W-1:0] cand);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cand;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent_log.push_back(cand);
        if (sent_log.size() > 600)
            void'(sent_log.pop_front());
    endtask

    // mostly fresh values aimed at a few busy buckets, plus replays and plain noise
    task send_random_run(input int count);
        logic [IMAGE_W-1:0] cand;
        int                 pick;
        for (int h = 0; h < HOT_CNT; h++)
            hot_low[h] = BUCKET_BITS'($urandom_range(BUCKET_CNT - 1));
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            cand = {$urandom, $urandom};
            if (pick < 30 && sent_log.size() != 0)
                cand = sent_log[$urandom_range(sent_log.size() - 1)];
            else if (pick < 80)
                cand[BUCKET_BITS-1:0] = hot_low[$urandom_range(HOT_CNT - 1)];
            send_candidate(cand);
        end
    endtask

    // The one-way map is a bijection, so two distinct candidates never share an
    // image: collision and halt cannot be provoked from the input side.
    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i])
            send_candidate(DIRECTED[i]);

        // no idling, with one long receiver hold-off while requests keep coming
        fork
            send_random_run(RANDOM_ITEMS);
            begin
                repeat (40) @(negedge aclk);
                hold_ready = 1'b1;
                repeat (300) @(negedge aclk);
                hold_ready = 1'b0;
            end
        join

        send_idle_pct = 56;
        send_random_run(RANDOM_ITEMS);

        send_idle_pct  = 0;
        recv_stall_pct = 56;
        send_random_run(RANDOM_ITEMS);

        send_idle_pct  = 34;
        recv_stall_pct = 34;
        send_random_run(RANDOM_ITEMS);

        s_tvalid <= 1'b0;
        while (tracker.awaited_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (tracker.errors == 0)
            $display("tb_hash_collision_search_unit passed");
        else
            $display("tb_hash_collision_search_unit failed");
        $finish;
    end

endmodule

`default_nettype wire
